// ===== rtl/tsbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbf_pkg
// Shared types, codes and small arithmetic helpers for the triangle sample
// blend fitness core.
// ----------------------------------------------------------------------------
package tsbf_pkg;

	// request operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DRAW   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam int unsigned SCORE_W = 18;

	// sequencer states
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_AREA  = 6'b001000,
		ST_SWEEP = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	// signed difference of two unsigned bytes
	function automatic logic signed [8:0] sdiff(input logic [7:0] a, input logic [7:0] b);
		sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// magnitude of a 19-bit signed value
	function automatic logic [18:0] mag19(input logic signed [18:0] v);
		mag19 = v[18] ? 19'(-v) : 19'(v);
	endfunction

	// floor(v / 255) for v up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
		div255 = t[15:8];
	endfunction

	// absolute difference of two bytes
	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		absdiff8 = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/triangle_sample_blend_fitness_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_sample_blend_fitness_core
// Scores alpha-blended triangles against target colors at stored sample points.
// ----------------------------------------------------------------------------
// A load request (operation 0) writes one sample and never raises busy. A
// draw request (operation 1) runs the setup and area states for the bounding
// box, edge coefficients and whole area, then one sample per cycle through a
// three-stage edge-test and blend datapath that reads and writes the sample
// stores, then a drain state that waits for the datapath to empty. A finish
// request (operation 2) sweeps the stores the same way, clearing each
// rendered color, and shows the score for exactly one cycle with score_valid
// high, in the first cycle after busy falls; the receiver cannot stall it.
// After reset the block runs a clearing pass over the rendered colors, with
// busy high. Operation 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module triangle_sample_blend_fitness_core #(
	parameter int unsigned SAMPLE_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  sample_index,
	input  logic [7:0]  x0,
	input  logic [7:0]  y0,
	input  logic [7:0]  x1,
	input  logic [7:0]  y1,
	input  logic [7:0]  x2,
	input  logic [7:0]  y2,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output logic        score_valid,
	output logic [17:0] score
);
	import tsbf_pkg::*;

	localparam int unsigned AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

	// sample stores
	logic [15:0] coord_mem  [SAMPLE_COUNT];
	logic [23:0] target_mem [SAMPLE_COUNT];
	logic [23:0] render_mem [SAMPLE_COUNT];

	state_t state_q;
	logic [AW:0] cnt_q;
	logic [AW-1:0] cnt_idx;
	logic cnt_last;
	logic accept;

	// latched request
	logic [1:0] op_q;
	logic [7:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [7:0] r_q, g_q, b_q, a_q;

	// per-triangle constants
	logic signed [8:0] e0a_q, e0b_q, e1a_q, e1b_q, e2a_q, e2b_q;
	logic [7:0] minx_q, maxx_q, miny_q, maxy_q;
	logic [15:0] ar_q, ag_q, ab_q;
	logic [7:0] inva_q;
	logic signed [17:0] pw0_q, pw1_q;
	logic [17:0] whole_q;

	// memory read data
	logic [15:0] coord_rd;
	logic [23:0] target_rd, render_rd;

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;

	// stage 2 registers
	logic signed [17:0] m0a_s2, m0b_s2, m1a_s2, m1b_s2, m2a_s2, m2b_s2;
	logic [15:0] ir_s2, ig_s2, ib_s2;
	logic inbox_s2;
	logic [9:0] dsum_s2;

	// stage 3 registers
	logic cover_s3;
	logic [23:0] color_s3;

	logic [17:0] acc_q;
	logic [17:0] score_q;
	logic score_valid_q;

	// load address
	logic [AW+7:0] load_ext;
	logic [AW-1:0] load_addr;
	logic load_ok;

	assign cnt_idx  = cnt_q[AW-1:0];
	assign cnt_last = (cnt_q == (AW+1)'(SAMPLE_COUNT - 1));
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;

	assign load_ext  = {{AW{1'b0}}, sample_index};
	assign load_addr = load_ext[AW-1:0];
	assign load_ok   = accept && (operation == OP_LOAD) &&
		(32'(sample_index) < 32'(SAMPLE_COUNT));

	assign score_valid = score_valid_q;
	assign score       = score_q;

	// render write port
	logic        rw_en;
	logic [AW-1:0] rw_addr;
	logic [23:0] rw_data;

	always_comb begin
		rw_en   = 1'b0;
		rw_addr = cnt_idx;
		rw_data = '0;
		if (state_q == ST_CLEAR) begin
			rw_en = 1'b1;
		end else if (load_ok) begin
			rw_en   = 1'b1;
			rw_addr = load_addr;
		end else if (v_s1 && (op_q == OP_FINISH)) begin
			rw_en   = 1'b1;
			rw_addr = idx_s1;
		end else if (v_s3 && cover_s3 && (op_q == OP_DRAW)) begin
			rw_en   = 1'b1;
			rw_addr = idx_s3;
			rw_data = color_s3;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		coord_rd  <= coord_mem[cnt_idx];
		target_rd <= target_mem[cnt_idx];
		render_rd <= render_mem[cnt_idx];
		if (load_ok) begin
			coord_mem[load_addr]  <= {y0, x0};
			target_mem[load_addr] <= {blue, green, red};
		end
		if (rw_en) begin
			render_mem[rw_addr] <= rw_data;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			ax_q <= x0;
			ay_q <= y0;
			bx_q <= x1;
			by_q <= y1;
			cx_q <= x2;
			cy_q <= y2;
			r_q  <= red;
			g_q  <= green;
			b_q  <= blue;
			a_q  <= alpha;
		end
	end

	// triangle setup: coefficients, bounding box, color products, area terms
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			e0a_q  <= sdiff(ay_q, by_q);
			e0b_q  <= sdiff(bx_q, ax_q);
			e1a_q  <= sdiff(ay_q, cy_q);
			e1b_q  <= sdiff(cx_q, ax_q);
			e2a_q  <= sdiff(cy_q, by_q);
			e2b_q  <= sdiff(bx_q, cx_q);
			minx_q <= (ax_q < bx_q) ? ((ax_q < cx_q) ? ax_q : cx_q)
				: ((bx_q < cx_q) ? bx_q : cx_q);
			maxx_q <= (ax_q > bx_q) ? ((ax_q > cx_q) ? ax_q : cx_q)
				: ((bx_q > cx_q) ? bx_q : cx_q);
			miny_q <= (ay_q < by_q) ? ((ay_q < cy_q) ? ay_q : cy_q)
				: ((by_q < cy_q) ? by_q : cy_q);
			maxy_q <= (ay_q > by_q) ? ((ay_q > cy_q) ? ay_q : cy_q)
				: ((by_q > cy_q) ? by_q : cy_q);
			ar_q   <= 16'(a_q) * 16'(r_q);
			ag_q   <= 16'(a_q) * 16'(g_q);
			ab_q   <= 16'(a_q) * 16'(b_q);
			inva_q <= 8'd255 - a_q;
			pw0_q  <= sdiff(cx_q, bx_q) * sdiff(ay_q, by_q);
			pw1_q  <= sdiff(cy_q, by_q) * sdiff(bx_q, ax_q);
		end
		if (state_q == ST_AREA) begin
			whole_q <= 18'(mag19(19'(pw0_q) + 19'(pw1_q)));
		end
	end

	// stage 1: edge products, blend products, finish channel differences
	logic [7:0] px_s1, py_s1;
	assign px_s1 = coord_rd[7:0];
	assign py_s1 = coord_rd[15:8];

	always_ff @(posedge clk) begin
		m0a_s2   <= sdiff(px_s1, bx_q) * e0a_q;
		m0b_s2   <= sdiff(py_s1, by_q) * e0b_q;
		m1a_s2   <= sdiff(px_s1, cx_q) * e1a_q;
		m1b_s2   <= sdiff(py_s1, cy_q) * e1b_q;
		m2a_s2   <= sdiff(px_s1, bx_q) * e2a_q;
		m2b_s2   <= sdiff(py_s1, by_q) * e2b_q;
		ir_s2    <= 16'(inva_q) * 16'(render_rd[7:0]);
		ig_s2    <= 16'(inva_q) * 16'(render_rd[15:8]);
		ib_s2    <= 16'(inva_q) * 16'(render_rd[23:16]);
		inbox_s2 <= (px_s1 >= minx_q) && (px_s1 <= maxx_q) &&
			(py_s1 >= miny_q) && (py_s1 <= maxy_q);
		dsum_s2  <= 10'(absdiff8(render_rd[7:0], target_rd[7:0])) +
			10'(absdiff8(render_rd[15:8], target_rd[15:8])) +
			10'(absdiff8(render_rd[23:16], target_rd[23:16]));
		idx_s2   <= idx_s1;
	end

	// stage 2: area test and blend division
	logic [19:0] area_sum;
	assign area_sum = 20'(mag19(19'(m0a_s2) + 19'(m0b_s2))) +
		20'(mag19(19'(m1a_s2) + 19'(m1b_s2))) +
		20'(mag19(19'(m2a_s2) + 19'(m2b_s2)));

	always_ff @(posedge clk) begin
		cover_s3 <= inbox_s2 && (area_sum == 20'(whole_q));
		color_s3 <= {div255(ab_q + ib_s2), div255(ag_q + ig_s2), div255(ar_q + ir_s2)};
		idx_s3   <= idx_s2;
	end

	// score accumulation with saturation
	logic [18:0] acc_next;
	assign acc_next = {1'b0, acc_q} + 19'(dsum_s2);

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			idx_s1        <= '0;
			acc_q         <= '0;
			score_q       <= '0;
			score_valid_q <= 1'b0;
		end else begin
			score_valid_q <= (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3 &&
				(op_q == OP_FINISH);
			v_s1          <= (state_q == ST_SWEEP);
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			idx_s1        <= cnt_idx;
			if (state_q == ST_IDLE) begin
				acc_q <= '0;
			end else if (v_s2 && (op_q == OP_FINISH)) begin
				acc_q <= acc_next[18] ? {SCORE_W{1'b1}} : acc_next[17:0];
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + (AW+1)'(1);
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (operation)
							OP_DRAW:   state_q <= ST_SETUP;
							OP_FINISH: state_q <= ST_SWEEP;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SETUP: begin
					state_q <= ST_AREA;
				end
				ST_AREA: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + (AW+1)'(1);
					if (cnt_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= '0;
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_IDLE;
						if (op_q == OP_FINISH) begin
							score_q <= acc_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
